// ===== design/assert_macros.svh =====
// shared assertion macros for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/smnf_pkg.sv =====
`default_nettype none

package smnf_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int TH_W = 9;
  localparam int ROW_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW_DEF = 3;
  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH = 2'd3;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [TH_W-1:0] THRESHOLD_LOW_RST = 9'd0;
  localparam logic [TH_W-1:0] THRESHOLD_HIGH_RST = 9'd256;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t gray;
    logic noise;
  } smnf_res_t;

endpackage

`default_nettype wire

// ===== design/switching_median_noise_filter.sv =====
// the input, window and result registers lie between the input transfer and the result
// throughput: one pixel per cycle unless stalled; line store read and written once per pixel
// no result for padding rows and columns that do not close an interior window
// reset (rst_n low, synchronous): counters, window and config registers return to defaults
// line store contents are not cleared and need no clearing pass
`default_nettype none

module switching_median_noise_filter import smnf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     in_gray_in,
  input  wire logic                 in_frame_start,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [PIX_W-1:0]     out_gray_out,
  output logic                      out_noise_mark,
  output logic                      out_frame_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int HALF = (WINDOW - 1) / 2;
  localparam int LINE_LEN = MAX_WIDTH + WINDOW - 1;
  localparam int CW = $clog2(LINE_LEN);
  localparam int PW = ((CW > CFG_W) ? CW : CFG_W) + 2;
  localparam int RPW = ROW_W + 1;
  localparam int LW = PIX_W * (WINDOW - 1);

  // configuration
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [TH_W-1:0]  threshold_low_r;
  logic [TH_W-1:0]  threshold_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      threshold_low_r <= THRESHOLD_LOW_RST;
      threshold_high_r <= THRESHOLD_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_THRESHOLD_LOW: threshold_low_r <= cfg_wdata[TH_W-1:0];
        CFG_THRESHOLD_HIGH: threshold_high_r <= cfg_wdata[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [PW-1:0]  w_ext;
  logic [PW-1:0]  w_eff;
  logic [PW-1:0]  pad_w;
  logic [RPW-1:0] h_eff;
  logic [RPW-1:0] pad_h;

  assign w_ext = PW'(frame_width_r);
  assign w_eff = (w_ext == '0) ? PW'(1) :
                 (w_ext > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : w_ext;
  assign pad_w = w_eff + PW'(WINDOW - 1);
  assign h_eff = (frame_height_r == '0) ? RPW'(1) : RPW'(frame_height_r);
  assign pad_h = h_eff + RPW'(WINDOW - 1);

  // pipeline control
  logic adv;
  logic in_accept;
  logic out_valid_r;

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_accept = in_valid && adv;

  // position counters
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [CW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic [PW-1:0]    col_inc;
  logic [RPW-1:0]   row_inc;

  assign cur_col = in_frame_start ? '0 : col_r;
  assign cur_row = in_frame_start ? '0 : row_r;
  assign col_inc = PW'(cur_col) + PW'(1);
  assign row_inc = RPW'(cur_row) + RPW'(1);

  always_comb begin
    col_nxt = col_inc[CW-1:0];
    row_nxt = cur_row;
    if (col_inc >= pad_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= pad_h) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read in flight
  logic             s1_valid_r;
  pix_t             s1_gray_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             fwd_hit_r;
  logic [LW-1:0]    fwd_data_r;
  logic [LW-1:0]    ram_rdata;
  logic [LW-1:0]    old_col;
  logic [LW-1:0]    wb_data;
  logic             ram_we;

  assign old_col = fwd_hit_r ? fwd_data_r : ram_rdata;
  // oldest line in the low slot; each line moves down one slot, new pixel on top
  assign wb_data = {s1_gray_r, old_col[LW-1:PIX_W]};
  assign ram_we = adv && s1_valid_r;

  smnf_ram #(
    .WIDTH (LW),
    .DEPTH (LINE_LEN)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (wb_data),
    .re    (in_accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      // same column written back while being read again
      fwd_hit_r <= s1_valid_r && (s1_col_r == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gray_r <= in_gray_in;
      s1_col_r <= cur_col;
      s1_row_r <= cur_row;
      fwd_data_r <= wb_data;
    end
  end

  // stage 2: window registers
  pix_t             wnd_r [WINDOW][WINDOW];
  logic             s2_valid_r;
  logic [CW-1:0]    s2_col_r;
  logic [ROW_W-1:0] s2_row_r;
  pix_t             new_col [WINDOW];

  for (genvar i = 0; i < WINDOW - 1; i++) begin : g_newcol
    assign new_col[i] = old_col[i*PIX_W +: PIX_W];
  end
  assign new_col[WINDOW-1] = s1_gray_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        for (int j = 0; j < WINDOW; j++) begin
          wnd_r[i][j] <= '0;
        end
      end
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        for (int i = 0; i < WINDOW; i++) begin
          for (int j = 0; j < WINDOW - 1; j++) begin
            wnd_r[i][j] <= wnd_r[i][j+1];
          end
          wnd_r[i][WINDOW-1] <= new_col[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end

  // decision on the window
  logic [WINDOW*WINDOW*PIX_W-1:0] wnd_flat;
  logic [WINDOW-1:0]              row_in;
  logic [WINDOW-1:0]              col_in;
  logic                           produced;
  logic                           last_pix;
  smnf_res_t                      res;

  for (genvar i = 0; i < WINDOW; i++) begin : g_flat_r
    for (genvar j = 0; j < WINDOW; j++) begin : g_flat_c
      assign wnd_flat[(i*WINDOW+j)*PIX_W +: PIX_W] = wnd_r[i][j];
    end
    // window line i sits at padded line row - (WINDOW-1) + i
    assign row_in[i] = (RPW'(s2_row_r) + RPW'(i) >= RPW'(WINDOW - 1 + HALF)) &&
                       (RPW'(s2_row_r) + RPW'(i) < h_eff + RPW'(WINDOW - 1 + HALF));
    assign col_in[i] = (PW'(s2_col_r) + PW'(i) >= PW'(WINDOW - 1 + HALF)) &&
                       (PW'(s2_col_r) + PW'(i) < w_eff + PW'(WINDOW - 1 + HALF));
  end

  assign produced = (s2_row_r >= ROW_W'(WINDOW - 1)) && (s2_col_r >= CW'(WINDOW - 1)) &&
                    (RPW'(s2_row_r) < pad_h) && (PW'(s2_col_r) < pad_w);
  assign last_pix = (RPW'(s2_row_r) == pad_h - RPW'(1)) && (PW'(s2_col_r) == pad_w - PW'(1));

  smnf_decide #(
    .WINDOW (WINDOW)
  ) u_decide (
    .wnd_flat (wnd_flat),
    .row_in   (row_in),
    .col_in   (col_in),
    .th_lo    (threshold_low_r),
    .th_hi    (threshold_high_r),
    .res      (res)
  );

  // result register
  logic out_valid_nxt;
  pix_t out_gray_r;
  logic out_noise_r;
  logic out_last_r;

  assign out_valid_nxt = s2_valid_r && produced;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && out_valid_nxt) begin
      out_gray_r <= res.gray;
      out_noise_r <= res.noise;
      out_last_r <= last_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_gray_out = out_gray_r;
  assign out_noise_mark = out_noise_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

// ===== design/smnf_ram.sv =====
`default_nettype none

module smnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/smnf_decide.sv =====
`default_nettype none

module smnf_decide import smnf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic [WINDOW*WINDOW*PIX_W-1:0] wnd_flat,
  input  wire logic [WINDOW-1:0]              row_in,
  input  wire logic [WINDOW-1:0]              col_in,
  input  wire logic [TH_W-1:0]                th_lo,
  input  wire logic [TH_W-1:0]                th_hi,
  output smnf_res_t                           res
);

  localparam int AREA = WINDOW * WINDOW;
  localparam int MID = (AREA - 1) / 2;
  localparam int HALF = (WINDOW - 1) / 2;
  localparam int RKW = $clog2(AREA);

  pix_t             vals [AREA];
  logic [AREA-1:0]  map_lo;
  logic [AREA-1:0]  map_hi;
  logic [AREA-1:0]  below [AREA];
  logic [RKW-1:0]   rank [AREA];
  pix_t             med;
  logic             maj_lo;
  logic             maj_hi;
  logic             noisy;
  pix_t             centre;

  for (genvar i = 0; i < WINDOW; i++) begin : g_row
    for (genvar j = 0; j < WINDOW; j++) begin : g_col
      assign vals[i*WINDOW+j] = wnd_flat[(i*WINDOW+j)*PIX_W +: PIX_W];
      // padding positions count as zero in both maps
      assign map_lo[i*WINDOW+j] = row_in[i] && col_in[j] &&
                                  ({1'b0, vals[i*WINDOW+j]} >= th_lo);
      assign map_hi[i*WINDOW+j] = row_in[i] && col_in[j] &&
                                  ({1'b0, vals[i*WINDOW+j]} >= th_hi);
    end
  end

  // rank of each element, ties broken by position, so every rank is taken once
  for (genvar k = 0; k < AREA; k++) begin : g_rank
    for (genvar m = 0; m < AREA; m++) begin : g_cmp
      if (m < k) begin : g_lo
        assign below[k][m] = vals[m] <= vals[k];
      end else begin : g_hi
        assign below[k][m] = vals[m] < vals[k];
      end
    end
    assign rank[k] = RKW'($countones(below[k]));
  end

  always_comb begin
    med = '0;
    for (int k = 0; k < AREA; k++) begin
      if (rank[k] == RKW'(MID)) begin
        med = med | vals[k];
      end
    end
  end

  assign centre = vals[HALF*WINDOW+HALF];
  assign maj_lo = $countones(map_lo) > MID;
  assign maj_hi = $countones(map_hi) > MID;
  assign noisy = (map_lo[HALF*WINDOW+HALF] != maj_lo) || (map_hi[HALF*WINDOW+HALF] != maj_hi);

  assign res.gray = noisy ? med : centre;
  assign res.noise = noisy;

endmodule

`default_nettype wire

// ===== design/smnf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module smnf_checker import smnf_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [PIX_W-1:0]     out_gray_out,
  input wire logic                 out_noise_mark,
  input wire logic                 out_frame_last
);

  // a stalled result stays offered
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `ASSERT_RST(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_gray_out) && $stable(out_noise_mark) && $stable(out_frame_last), "stalled result changed")

  // input only backs up behind a held result
  `ASSERT_ALL(a_stall_cause, clk, in_stall |-> out_valid && out_stall, "input stalled with free output")

  // reset empties the result register
  `ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind switching_median_noise_filter smnf_checker u_smnf_checker (.*);

`default_nettype wire
